>>> hw/rtl/eight_bit_alu_with_flags_macros.svh
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_macros
// assertion macros shared by the alu pipeline
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

// same-cycle implication, off during reset
`define ALU8F_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("alu8f assertion failed");

// next-cycle implication, off during reset
`define ALU8F_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("alu8f assertion failed");

`endif

>>> hw/rtl/alu8f_pkg.sv
// ----------------------------------------------------------------------------
// alu8f_pkg
// opcodes, stage records and constants of the eight-bit alu pipeline
// ----------------------------------------------------------------------------
package alu8f_pkg;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [3:0] NIB_MAX   = 4'hF;
    localparam logic [3:0] DEC_DIGIT = 4'd9;
    localparam logic [8:0] DAA_LIMIT = 9'h09F;
    localparam logic [8:0] DAA_HIGH  = 9'h060;
    localparam logic [8:0] DAA_LOW   = 9'h006;

    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_ADC    = 5'd1,
        CMD_SUB    = 5'd2,
        CMD_SBC    = 5'd3,
        CMD_AND    = 5'd4,
        CMD_OR     = 5'd5,
        CMD_XOR    = 5'd6,
        CMD_CP     = 5'd7,
        CMD_INC    = 5'd8,
        CMD_DEC    = 5'd9,
        CMD_ADD16  = 5'd10,
        CMD_ADDSP  = 5'd11,
        CMD_LDHLSP = 5'd12,
        CMD_RLC    = 5'd13,
        CMD_RRC    = 5'd14,
        CMD_RL     = 5'd15,
        CMD_RR     = 5'd16,
        CMD_SLA    = 5'd17,
        CMD_SRA    = 5'd18,
        CMD_SWAP   = 5'd19,
        CMD_SRL    = 5'd20,
        CMD_BIT    = 5'd21,
        CMD_RLCA   = 5'd22,
        CMD_RRCA   = 5'd23,
        CMD_RLA    = 5'd24,
        CMD_RRA    = 5'd25,
        CMD_DAA    = 5'd26
    } cmd_t;

    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } sh_op_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  a;
        logic [7:0]  v;
        logic [15:0] pair;
        logic [15:0] word;
        logic [2:0]  bix;
        flags_t      f;
        sh_op_t      sh;
        logic [7:0]  sh_src;
        logic        cin;
    } s1_t;

    typedef struct packed {
        logic [7:0]  rb;
        logic [15:0] rw;
        flags_t      f;
        logic        z_from_rb;
    } s2_t;

endpackage

>>> hw/rtl/alu8f_decode.sv
// ----------------------------------------------------------------------------
// alu8f_decode
// first stage: unpacks the input item and prepares shift and carry selects
// ----------------------------------------------------------------------------
module alu8f_decode
    import alu8f_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [IN_DATA_W-1:0] in_data,
    output logic                 valid_reg,
    output s1_t                  s1_reg
);

    logic [4:0] cmd_raw;
    logic [4:0] sh_idx;
    logic       is_acc_rot;
    s1_t        s1_next;

    always_comb begin
        cmd_raw    = in_data[4:0];
        is_acc_rot = (cmd_raw >= CMD_RLCA) && (cmd_raw <= CMD_RRA);
        sh_idx     = is_acc_rot ? (cmd_raw - CMD_RLCA) : (cmd_raw - CMD_RLC);

        s1_next.cmd    = cmd_t'(cmd_raw);
        s1_next.a      = in_data[12:5];
        s1_next.v      = in_data[20:13];
        s1_next.pair   = in_data[36:21];
        s1_next.word   = in_data[52:37];
        s1_next.bix    = in_data[55:53];
        s1_next.f.z    = in_data[56];
        s1_next.f.n    = in_data[57];
        s1_next.f.h    = in_data[58];
        s1_next.f.c    = in_data[59];
        s1_next.sh     = sh_op_t'(sh_idx[2:0]);
        s1_next.sh_src = is_acc_rot ? in_data[12:5] : in_data[20:13];
        s1_next.cin    = ((cmd_raw == CMD_ADC) || (cmd_raw == CMD_SBC)) ? in_data[59] : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= s1_next;
        end
    end

endmodule

>>> hw/rtl/alu8f_execute.sv
// ----------------------------------------------------------------------------
// alu8f_execute
// second stage: adders, shifter, bit test and decimal adjust
// ----------------------------------------------------------------------------
module alu8f_execute
    import alu8f_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  logic in_valid,
    input  s1_t  s1,
    output logic valid_reg,
    output s2_t  s2_reg
);

    logic [8:0]  sum9;
    logic [4:0]  sum_nib;
    logic [8:0]  diff9;
    logic [4:0]  diff_nib;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] sp_sum;
    logic [4:0]  sp_nib;
    logic [8:0]  sp_byte;
    logic [7:0]  sh_res;
    logic        sh_c;
    logic [8:0]  daa_t1;
    logic [8:0]  daa_t2;
    s2_t         s2_next;

    always_comb begin
        sum9     = {1'b0, s1.a} + {1'b0, s1.v} + {8'd0, s1.cin};
        sum_nib  = {1'b0, s1.a[3:0]} + {1'b0, s1.v[3:0]} + {4'd0, s1.cin};
        diff9    = {1'b0, s1.a} - {1'b0, s1.v} - {8'd0, s1.cin};
        diff_nib = {1'b0, s1.a[3:0]} - {1'b0, s1.v[3:0]} - {4'd0, s1.cin};
        sum17    = {1'b0, s1.pair} + {1'b0, s1.word};
        sum13    = {1'b0, s1.pair[11:0]} + {1'b0, s1.word[11:0]};
        sp_sum   = s1.pair + {{8{s1.v[7]}}, s1.v};
        sp_nib   = {1'b0, s1.pair[3:0]} + {1'b0, s1.v[3:0]};
        sp_byte  = {1'b0, s1.pair[7:0]} + {1'b0, s1.v};

        case (s1.sh)
            SH_RLC:  begin sh_c = s1.sh_src[7]; sh_res = {s1.sh_src[6:0], s1.sh_src[7]}; end
            SH_RRC:  begin sh_c = s1.sh_src[0]; sh_res = {s1.sh_src[0], s1.sh_src[7:1]}; end
            SH_RL:   begin sh_c = s1.sh_src[7]; sh_res = {s1.sh_src[6:0], s1.f.c}; end
            SH_RR:   begin sh_c = s1.sh_src[0]; sh_res = {s1.f.c, s1.sh_src[7:1]}; end
            SH_SLA:  begin sh_c = s1.sh_src[7]; sh_res = {s1.sh_src[6:0], 1'b0}; end
            SH_SRA:  begin sh_c = s1.sh_src[0]; sh_res = {s1.sh_src[7], s1.sh_src[7:1]}; end
            SH_SWAP: begin sh_c = 1'b0; sh_res = {s1.sh_src[3:0], s1.sh_src[7:4]}; end
            default: begin sh_c = s1.sh_src[0]; sh_res = {1'b0, s1.sh_src[7:1]}; end
        endcase

        // decimal adjust, add and subtract forms
        if (!s1.f.n) begin
            daa_t1 = (s1.f.h || (s1.a[3:0] > DEC_DIGIT)) ? ({1'b0, s1.a} + DAA_LOW)
                                                         : {1'b0, s1.a};
            daa_t2 = (s1.f.c || (daa_t1 > DAA_LIMIT)) ? (daa_t1 + DAA_HIGH) : daa_t1;
        end else begin
            daa_t1 = s1.f.h ? {1'b0, s1.a - DAA_LOW[7:0]} : {1'b0, s1.a};
            daa_t2 = s1.f.c ? {1'b0, daa_t1[7:0] - DAA_HIGH[7:0]} : daa_t1;
        end

        s2_next.rb        = s1.a;
        s2_next.rw        = 16'd0;
        s2_next.f         = s1.f;
        s2_next.z_from_rb = 1'b0;

        case (s1.cmd)
            CMD_ADD, CMD_ADC: begin
                s2_next.rb        = sum9[7:0];
                s2_next.f.n       = 1'b0;
                s2_next.f.h       = sum_nib[4];
                s2_next.f.c       = sum9[8];
                s2_next.z_from_rb = 1'b1;
            end
            CMD_SUB, CMD_SBC, CMD_CP: begin
                s2_next.rb  = diff9[7:0];
                s2_next.f.z = (diff9[7:0] == 8'd0);
                s2_next.f.n = 1'b1;
                s2_next.f.h = diff_nib[4];
                s2_next.f.c = diff9[8];
                if (s1.cmd == CMD_CP) begin
                    s2_next.rb = s1.a;
                end
            end
            CMD_AND, CMD_OR, CMD_XOR: begin
                s2_next.rb = (s1.cmd == CMD_AND) ? (s1.a & s1.v) :
                             (s1.cmd == CMD_OR)  ? (s1.a | s1.v) : (s1.a ^ s1.v);
                s2_next.f.n       = 1'b0;
                s2_next.f.h       = (s1.cmd == CMD_AND);
                s2_next.f.c       = 1'b0;
                s2_next.z_from_rb = 1'b1;
            end
            CMD_INC: begin
                s2_next.rb        = s1.v + 8'd1;
                s2_next.f.n       = 1'b0;
                s2_next.f.h       = (s1.v[3:0] == NIB_MAX);
                s2_next.z_from_rb = 1'b1;
            end
            CMD_DEC: begin
                s2_next.rb        = s1.v - 8'd1;
                s2_next.f.n       = 1'b1;
                s2_next.f.h       = (s1.v[3:0] == 4'd0);
                s2_next.z_from_rb = 1'b1;
            end
            CMD_ADD16: begin
                s2_next.rw  = sum17[15:0];
                s2_next.f.n = 1'b0;
                s2_next.f.h = sum13[12];
                s2_next.f.c = sum17[16];
            end
            CMD_ADDSP, CMD_LDHLSP: begin
                s2_next.rw  = sp_sum;
                s2_next.f.z = 1'b0;
                s2_next.f.n = 1'b0;
                s2_next.f.h = sp_nib[4];
                s2_next.f.c = sp_byte[8];
            end
            CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SWAP, CMD_SRL: begin
                s2_next.rb        = sh_res;
                s2_next.f.n       = 1'b0;
                s2_next.f.h       = 1'b0;
                s2_next.f.c       = sh_c;
                s2_next.z_from_rb = 1'b1;
            end
            CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA: begin
                s2_next.rb  = sh_res;
                s2_next.f.z = 1'b0;
                s2_next.f.n = 1'b0;
                s2_next.f.h = 1'b0;
                s2_next.f.c = sh_c;
            end
            CMD_BIT: begin
                s2_next.rb  = s1.v;
                s2_next.f.z = ~s1.v[s1.bix];
                s2_next.f.n = 1'b0;
                s2_next.f.h = 1'b1;
            end
            CMD_DAA: begin
                s2_next.rb        = daa_t2[7:0];
                s2_next.f.h       = 1'b0;
                s2_next.f.c       = s1.f.c | (~s1.f.n & daa_t2[8]);
                s2_next.z_from_rb = 1'b1;
            end
            default: begin
                s2_next.rb = s1.a;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg <= s2_next;
        end
    end

endmodule

>>> hw/rtl/alu8f_writeback.sv
// ----------------------------------------------------------------------------
// alu8f_writeback
// last stage: zero flag from the result byte for commands that take it, and the output register
// ----------------------------------------------------------------------------
module alu8f_writeback
    import alu8f_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  s2_t                   s2,
    output logic                  valid_reg,
    output logic [OUT_DATA_W-1:0] data_reg
);

    flags_t                f_next;
    logic [OUT_DATA_W-1:0] data_next;

    always_comb begin
        f_next   = s2.f;
        if (s2.z_from_rb) begin
            f_next.z = (s2.rb == 8'd0);
        end
        data_next = {4'd0, f_next.c, f_next.h, f_next.n, f_next.z, s2.rw, s2.rb};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> hw/rtl/eight_bit_alu_with_flags.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// eight-bit cpu alu with z, n, h and c flags, three-stage pipeline
// ----------------------------------------------------------------------------
// One item in, one result out. The block takes a new item every clock while
// the writeback register is empty or m_tready is high. Each item passes
// through the decode, execute and writeback registers in that order.
// When m_tready is low while the writeback register holds a result, all
// three stages hold together and s_tready drops; bubbles in the earlier
// stages are not squeezed out. Opcodes 27 to 31 return the accumulator with
// flags unchanged and a zero word.
// ----------------------------------------------------------------------------
`include "eight_bit_alu_with_flags_macros.svh"

module eight_bit_alu_with_flags
    import alu8f_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command, accumulator, operand, pair_value, operand_word, bit_index,
    // zero_in, subtract_in, half_carry_in, carry_in
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_byte, result_word, zero_out, subtract_out, half_carry_out, carry_out
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic adv;
    logic v1;
    logic v2;
    logic v3;
    s1_t  s1;
    s2_t  s2;

    assign adv      = !v3 || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v3;

    alu8f_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .valid_reg (v1),
        .s1_reg    (s1)
    );

    alu8f_execute u_execute (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v1),
        .s1        (s1),
        .valid_reg (v2),
        .s2_reg    (s2)
    );

    alu8f_writeback u_writeback (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v2),
        .s2        (s2),
        .valid_reg (v3),
        .data_reg  (m_tdata)
    );

    `ALU8F_ASSERT_NEXT(a_valid_shift, adv, (v2 == $past(v1)) && (v3 == $past(v2)))
    `ALU8F_ASSERT_NEXT(a_stall_hold, !adv, $stable(v1) && $stable(v2) && $stable(v3))
    `ALU8F_ASSERT_NEXT(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready, m_tvalid)

endmodule
